// ===== rtl/bdasc_pkg.sv =====
// Package for the binary to decimal ASCII core: types, constants and weight functions.
`default_nettype none

package bdasc_pkg;

   localparam int VALUE_FIELD_WIDTH   = 32;
   localparam int VALUE_WIDTH_DEFAULT = 32;
   localparam int MAX_VALUE_WIDTH     = 64;
   localparam int QUEUE_DEPTH         = 2;

   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;

   typedef struct packed {
      logic [VALUE_FIELD_WIDTH-1:0] value;
      logic                         is_signed;
   } req_type;

   typedef struct packed {
      logic [7:0] char_code;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic full;
      logic nonempty;
   } queue_status_type;

   // d * 10^k, elaboration use only
   function automatic logic [MAX_VALUE_WIDTH+3:0] dec_weight(input int k, input int d);
      logic [MAX_VALUE_WIDTH+3:0] p;
      p = (MAX_VALUE_WIDTH+4)'(d);
      for (int i = 0; i < k; i++) begin
         p = p * (MAX_VALUE_WIDTH+4)'(10);
      end
      return p;
   endfunction

   // decimal digits needed for the largest w-bit value
   function automatic int dec_digits(input int w);
      logic [MAX_VALUE_WIDTH+3:0] top;
      logic [MAX_VALUE_WIDTH+3:0] p;
      int n;
      top = ((MAX_VALUE_WIDTH+4)'(1) << w) - (MAX_VALUE_WIDTH+4)'(1);
      p = (MAX_VALUE_WIDTH+4)'(10);
      n = 1;
      for (int i = 0; i < 24; i++) begin
         if (p <= top) begin
            n = n + 1;
            p = p * (MAX_VALUE_WIDTH+4)'(10);
         end
      end
      return n;
   endfunction

   function automatic int idx_bits(input int w);
      return $clog2(dec_digits(w));
   endfunction

endpackage

`default_nettype wire

// ===== rtl/bdasc_queue.sv =====
// Small FIFO between the classifying front end and the digit emitting back end.
`default_nettype none

module bdasc_queue import bdasc_pkg::*; #(
   parameter int DATA_WIDTH = 8,
   parameter int DEPTH      = QUEUE_DEPTH
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire logic [DATA_WIDTH-1:0] push_data,
   input  wire logic                  pop,
   output logic      [DATA_WIDTH-1:0] pop_data,
   output queue_status_type           status
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [DATA_WIDTH-1:0] slot_ff [DEPTH];
   logic [PW-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]         count_ff, count_in;
   logic                  do_push, do_pop;

   assign status.full     = (count_ff == CW'(DEPTH));
   assign status.nonempty = (count_ff != '0);
   assign do_push  = push & ~status.full;
   assign do_pop   = pop & status.nonempty;
   assign pop_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/bdasc_front.sv =====
// Front end: takes a beat, forms sign and magnitude, finds the index of its top decimal digit.
`default_nettype none

module bdasc_front import bdasc_pkg::*; #(
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEFAULT
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   output logic                                    busy,
   input  wire req_type                            req,
   input  wire queue_status_type                   q_status,
   output logic                                    push,
   output logic      [VALUE_WIDTH-1:0]             push_mag,
   output logic                                    push_neg,
   output logic      [idx_bits(VALUE_WIDTH)-1:0]   push_top
);

   localparam int DIGITS   = dec_digits(VALUE_WIDTH);
   localparam int KW       = idx_bits(VALUE_WIDTH);
   localparam int EW       = VALUE_WIDTH + 4;
   localparam int VAL_BITS = (VALUE_WIDTH < VALUE_FIELD_WIDTH) ? VALUE_WIDTH
                                                                 : VALUE_FIELD_WIDTH;

   logic [EW-1:0]          pow_tab [1:DIGITS-1];
   logic [VALUE_WIDTH-1:0] v;
   logic                   neg;
   logic                   accept;
   logic                   a_valid_ff, a_valid_in;
   logic                   a_neg_ff;
   logic [VALUE_WIDTH-1:0] a_mag_ff;
   logic [KW-1:0]          top_cnt;

   for (genvar k = 1; k < DIGITS; k++) begin : g_pow
      assign pow_tab[k] = EW'(dec_weight(k, 1));
   end

   assign v      = VALUE_WIDTH'(req.value[VAL_BITS-1:0]);
   assign neg    = req.is_signed & v[VALUE_WIDTH-1];
   assign push   = a_valid_ff & ~q_status.full;
   assign busy   = a_valid_ff & q_status.full;
   assign accept = start & ~busy;
   assign a_valid_in = accept | (a_valid_ff & ~push);

   always_comb begin
      top_cnt = '0;
      for (int k = 1; k < DIGITS; k++) begin
         if ({4'b0000, a_mag_ff} >= pow_tab[k]) begin
            top_cnt = top_cnt + KW'(1);
         end
      end
   end

   assign push_mag = a_mag_ff;
   assign push_neg = a_neg_ff;
   assign push_top = top_cnt;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_neg_ff <= neg;
         a_mag_ff <= neg ? (~v) + VALUE_WIDTH'(1) : v;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/bdasc_back.sv =====
// Back end: emits the minus sign and one decimal digit per cycle, most significant first.
`default_nettype none

module bdasc_back import bdasc_pkg::*; #(
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEFAULT
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire queue_status_type                 q_status,
   output logic                                  pop,
   input  wire logic [VALUE_WIDTH-1:0]           pop_mag,
   input  wire logic                             pop_neg,
   input  wire logic [idx_bits(VALUE_WIDTH)-1:0] pop_top,
   output logic                                  rsp_valid,
   output rsp_type                               rsp
);

   localparam int DIGITS = dec_digits(VALUE_WIDTH);
   localparam int KW     = idx_bits(VALUE_WIDTH);
   localparam int EW     = VALUE_WIDTH + 4;

   logic [EW-1:0]          mult_tab [DIGITS][10];
   logic                   active_ff, active_in;
   logic                   sign_ff, sign_in;
   logic [VALUE_WIDTH-1:0] rem_ff, rem_in;
   logic [KW-1:0]          k_ff, k_in;
   logic [3:0]             digit;
   logic [EW-1:0]          sel;
   logic                   finishing;
   logic                   rsp_valid_ff;
   rsp_type                rsp_ff, rsp_in;

   for (genvar k = 0; k < DIGITS; k++) begin : g_row
      for (genvar d = 0; d < 10; d++) begin : g_col
         assign mult_tab[k][d] = EW'(dec_weight(k, d));
      end
   end

   always_comb begin
      digit = '0;
      for (int d = 1; d < 10; d++) begin
         if ({4'b0000, rem_ff} >= mult_tab[k_ff][d]) begin
            digit = digit + 4'd1;
         end
      end
   end

   assign sel       = mult_tab[k_ff][digit];
   assign finishing = active_ff & ~sign_ff & (k_ff == '0);
   assign pop       = q_status.nonempty & (~active_ff | finishing);

   always_comb begin
      active_in = active_ff;
      sign_in   = sign_ff;
      rem_in    = rem_ff;
      k_in      = k_ff;
      if (pop) begin
         active_in = 1'b1;
         sign_in   = pop_neg;
         rem_in    = pop_mag;
         k_in      = pop_top;
      end else if (finishing) begin
         active_in = 1'b0;
      end else if (active_ff) begin
         if (sign_ff) begin
            sign_in = 1'b0;
         end else begin
            rem_in = rem_ff - sel[VALUE_WIDTH-1:0];
            k_in   = k_ff - KW'(1);
         end
      end
   end

   always_comb begin
      rsp_in.char_code = sign_ff ? CHAR_MINUS : CHAR_ZERO + {4'b0000, digit};
      rsp_in.last      = ~sign_ff & (k_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         sign_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         sign_ff      <= sign_in;
         rsp_valid_ff <= active_ff;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      k_ff   <= k_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

`default_nettype wire

// ===== rtl/binary_to_decimal_ascii_core.sv =====
// Top level of the binary to decimal ASCII core.
//
// Input: a beat {value, is_signed} on req_payload is taken when start is high
// and busy is low. Output: one ASCII character per beat on rsp_payload, marked
// by rsp_valid for exactly one cycle; rsp_payload.last flags the final
// character. Negative signed values get a leading '-'; leading zeros are
// dropped, zero prints as a single '0'.
// The first character passes the front end's input stage, the queue slot, the
// back end's state and its output register. Throughput: one character per
// cycle, set by the one-character output port; an item has 1 to 11 characters
// (at VALUE_WIDTH = 32). The back end emits one digit a cycle by comparing the
// remainder against nine multiples of the current power of ten. Queued items
// follow each other with no gap; a two-beat queue decouples the front end,
// which raises busy only when the queue and its input stage are both full.
// Reset clears all control state; no clearing pass is needed.
// The receiver cannot stall; results are never held back.
`default_nettype none

module binary_to_decimal_ascii_core import bdasc_pkg::*; #(
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEFAULT
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_payload,
   output logic         rsp_valid,
   output rsp_type      rsp_payload
);

   localparam int KW = idx_bits(VALUE_WIDTH);
   localparam int QW = VALUE_WIDTH + 1 + KW;

   queue_status_type       q_status;
   logic                   push, pop;
   logic [VALUE_WIDTH-1:0] push_mag, pop_mag;
   logic                   push_neg, pop_neg;
   logic [KW-1:0]          push_top, pop_top;
   logic [QW-1:0]          pop_data;

   bdasc_front #(.VALUE_WIDTH(VALUE_WIDTH)) u_front (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req      (req_payload),
      .q_status (q_status),
      .push     (push),
      .push_mag (push_mag),
      .push_neg (push_neg),
      .push_top (push_top)
   );

   bdasc_queue #(.DATA_WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data ({push_mag, push_neg, push_top}),
      .pop       (pop),
      .pop_data  (pop_data),
      .status    (q_status)
   );

   assign {pop_mag, pop_neg, pop_top} = pop_data;

   bdasc_back #(.VALUE_WIDTH(VALUE_WIDTH)) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_status  (q_status),
      .pop       (pop),
      .pop_mag   (pop_mag),
      .pop_neg   (pop_neg),
      .pop_top   (pop_top),
      .rsp_valid (rsp_valid),
      .rsp       (rsp_payload)
   );

`ifndef ASSERT_OFF
   a_minus_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.char_code == CHAR_MINUS) |-> !rsp_payload.last)
      else $error("minus sign flagged as last character");

   a_minus_then_digit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.char_code == CHAR_MINUS) |=>
         rsp_valid && (rsp_payload.char_code != CHAR_MINUS))
      else $error("minus sign not followed by a digit");

   a_no_gap_in_number: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.last |=> rsp_valid)
      else $error("gap inside a number");

   a_busy_only_when_full: assert property (@(posedge clock) disable iff (reset)
      busy |-> q_status.full)
      else $error("busy raised with room in the queue");
`endif

endmodule

`default_nettype wire
